// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the site character count profile rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCCP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SCCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sccp_pkg.sv -----
// package for the site character count profile: codes, widths, shared types
// no dependencies; used by sccp_if, sccp_cfg, sccp_engine and the top level
package sccp_pkg;

  localparam int DEF_MAX_SITES    = 4096;
  localparam int DEF_ALPHABET_MAX = 8;
  localparam int DEF_COUNT_BITS   = 32;

  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int WEIGHT_W   = 32;
  localparam int QSITE_W    = 12;
  localparam int QIDX_W     = 3;
  localparam int OUT_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int SITE_POS_W = 13;
  localparam int LEN_W      = 17;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 64;

  localparam logic [SITE_POS_W-1:0] POS_SAT = 13'd8191;
  localparam logic [12:0] SITE_COUNT_RST = 13'd4096;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD        = 2'd0,
    FUNC_READ_CHAR  = 2'd1,
    FUNC_READ_INDEX = 2'd2,
    FUNC_CLEAR      = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  localparam logic [1:0] REG_ALPHABET_CHARS = 2'd0;
  localparam logic [1:0] REG_ALPHABET_SIZE  = 2'd1;
  localparam logic [1:0] REG_SITE_COUNT     = 2'd2;

  typedef struct packed {
    logic [63:0] alphabet_chars;
    logic [3:0]  alphabet_size;
    logic [12:0] site_count;
  } sccp_cfg_t;

  typedef struct packed {
    logic clearing;
    logic item_write;
  } sccp_mon_t;

  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

endpackage

// ----- rtl/core/sccp_if.sv -----
// valid/ready channel interfaces for the input and result beats
// depends on sccp_pkg for field widths
interface sccp_in_if;
  import sccp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [CHAR_W-1:0]     site_char;
  logic [WEIGHT_W-1:0]   weight;
  logic                  last_of_sequence;
  logic [QSITE_W-1:0]    query_site;
  logic [QIDX_W-1:0]     query_char_index;

  modport source(output valid, func, site_char, weight, last_of_sequence, query_site,
                 query_char_index, input ready);
  modport sink(input valid, func, site_char, weight, last_of_sequence, query_site,
               query_char_index, output ready);
endinterface

interface sccp_out_if;
  import sccp_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_W-1:0]    count_value;
  logic [OUT_W-1:0]    sequences_total;
  logic [STATUS_W-1:0] status;

  modport source(output valid, count_value, sequences_total, status, input ready);
  modport sink(input valid, count_value, sequences_total, status, output ready);
endinterface

// ----- rtl/core/sccp_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module sccp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/sccp_cfg.sv -----
// apb-style configuration registers: alphabet characters, size, site count
// depends on sccp_pkg for register codes and the config struct
module sccp_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sccp_pkg::APB_AW-1:0] paddr,
  input  logic [sccp_pkg::APB_DW-1:0] pwdata,
  output logic [sccp_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output sccp_pkg::sccp_cfg_t       cfg
);
  import sccp_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alphabet_chars <= '0;
      cfg.alphabet_size  <= '0;
      cfg.site_count     <= SITE_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ALPHABET_CHARS: cfg.alphabet_chars <= pwdata;
        REG_ALPHABET_SIZE:  cfg.alphabet_size  <= pwdata[3:0];
        REG_SITE_COUNT:     cfg.site_count     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ALPHABET_CHARS: prdata = cfg.alphabet_chars;
      REG_ALPHABET_SIZE:  prdata = {60'd0, cfg.alphabet_size};
      REG_SITE_COUNT:     prdata = {51'd0, cfg.site_count};
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/sccp_engine.sv -----
// count engine: sequence state, read-modify-write on the count ram, clearing pass
// depends on sccp_pkg, sccp_if and sccp_ram
module sccp_engine #(
  parameter int MAX_SITES    = sccp_pkg::DEF_MAX_SITES,
  parameter int ALPHABET_MAX = sccp_pkg::DEF_ALPHABET_MAX,
  parameter int COUNT_BITS   = sccp_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  sccp_pkg::sccp_cfg_t cfg,
  sccp_in_if.sink             in_ch,
  sccp_out_if.source          out_ch,
  output sccp_pkg::sccp_mon_t mon
);
  import sccp_pkg::*;

  localparam int DEPTH = MAX_SITES * ALPHABET_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = COUNT_BITS;
  localparam int EW    = ((CW > WEIGHT_W) ? CW : WEIGHT_W) + 1;
  localparam logic [EW-1:0]    CMASK_E   = (EW'(1) << CW) - EW'(1);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_SITES);
  localparam logic [3:0]       MAX_ALPHA = 4'(ALPHABET_MAX);

  // sequence state
  logic [SITE_POS_W-1:0] site_position, site_position_next;
  logic [CW-1:0]         sequences_added, sequences_added_next;
  logic                  sequence_rejected, sequence_rejected_next;
  logic                  length_error, length_error_next;

  // decode
  logic                  accept;
  logic [LEN_W-1:0]      len;
  logic [3:0]            na;
  logic [CHAR_W-1:0]     char_up;
  logic                  hit;
  logic [QIDX_W-1:0]     found_idx;
  logic                  first, rej, le, in_range;
  logic [SITE_POS_W-1:0] pos_inc;
  logic [EW-1:0]         wext;
  logic [CW-1:0]         w_cw;
  logic                  do_write, do_read;
  status_t               res_status;
  logic [SITE_POS_W-1:0] addr_site;
  logic [QIDX_W-1:0]     addr_idx;
  logic [AW-1:0]         rd_addr;

  // read stage
  logic                  s1_valid, s1_wr, s1_rd, s1_fwd, s1_adv;
  logic [AW-1:0]         s1_addr;
  logic [CW-1:0]         s1_weight, s1_total, fwd_data;
  status_t               s1_status;
  logic [CW-1:0]         s1_data, s1_sum;
  logic                  item_write;

  // ram and clearing pass
  logic                  clearing;
  logic [AW-1:0]         sweep_addr;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CW-1:0]         ram_wdata, ram_rdata;

  // output register
  logic                  out_valid;

  assign accept = in_ch.valid && in_ch.ready;
  assign len    = (LEN_W'(cfg.site_count) > MAX_LEN) ? MAX_LEN : LEN_W'(cfg.site_count);
  assign na     = (cfg.alphabet_size > MAX_ALPHA) ? MAX_ALPHA : cfg.alphabet_size;
  assign char_up = upcase(in_ch.site_char);
  assign wext   = EW'(in_ch.weight);
  assign w_cw   = CW'(in_ch.weight);

  // lowest matching alphabet index wins
  always_comb begin
    hit       = 1'b0;
    found_idx = '0;
    for (int k = ALPHABET_MAX - 1; k >= 0; k--) begin
      if (4'(k) < na && upcase(cfg.alphabet_chars[8*k +: 8]) == char_up) begin
        hit       = 1'b1;
        found_idx = QIDX_W'(k);
      end
    end
  end

  always_comb begin
    site_position_next     = site_position;
    sequences_added_next   = sequences_added;
    sequence_rejected_next = sequence_rejected;
    length_error_next      = length_error;
    first      = (site_position == '0);
    rej        = first ? ((wext > CMASK_E) || ((EW'(sequences_added) + wext) >= CMASK_E))
                       : sequence_rejected;
    le         = first ? 1'b0 : length_error;
    in_range   = LEN_W'(site_position) < len;
    pos_inc    = (site_position < POS_SAT) ? site_position + 13'd1 : site_position;
    do_write   = 1'b0;
    do_read    = 1'b0;
    res_status = ST_OK;
    addr_site  = site_position;
    addr_idx   = found_idx;
    case (func_t'(in_ch.func))
      FUNC_ADD: begin
        if (!rej) begin
          if (in_range) begin
            do_write = hit;
          end else begin
            le = 1'b1;
          end
        end
        if (in_ch.last_of_sequence && !rej) begin
          if (LEN_W'(pos_inc) != len) begin
            le = 1'b1;
          end
          sequences_added_next = sequences_added + w_cw;
        end
        res_status = rej ? ST_REJECTED : (le ? ST_LENGTH : ST_OK);
        if (in_ch.last_of_sequence) begin
          site_position_next     = '0;
          sequence_rejected_next = 1'b0;
          length_error_next      = 1'b0;
        end else begin
          site_position_next     = pos_inc;
          sequence_rejected_next = rej;
          length_error_next      = le;
        end
      end
      FUNC_READ_CHAR: begin
        addr_site = {1'b0, in_ch.query_site};
        if (LEN_W'(in_ch.query_site) < len && hit) begin
          do_read = 1'b1;
        end else begin
          res_status = ST_INVALID;
        end
      end
      FUNC_READ_INDEX: begin
        addr_site = {1'b0, in_ch.query_site};
        addr_idx  = in_ch.query_char_index;
        if (LEN_W'(in_ch.query_site) < len && 4'(in_ch.query_char_index) < na) begin
          do_read = 1'b1;
        end else begin
          res_status = ST_INVALID;
        end
      end
      FUNC_CLEAR: begin
        sequences_added_next   = '0;
        site_position_next     = '0;
        sequence_rejected_next = 1'b0;
        length_error_next      = 1'b0;
      end
      default: ;
    endcase
  end

  assign rd_addr = AW'(addr_site) * AW'(ALPHABET_MAX) + AW'(addr_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      site_position     <= '0;
      sequences_added   <= '0;
      sequence_rejected <= 1'b0;
      length_error      <= 1'b0;
    end else if (accept) begin
      site_position     <= site_position_next;
      sequences_added   <= sequences_added_next;
      sequence_rejected <= sequence_rejected_next;
      length_error      <= length_error_next;
    end
  end

  // read stage holds its ram word while stalled, writes back as it moves on
  assign s1_adv     = !out_valid || out_ch.ready;
  assign in_ch.ready = !clearing && (!s1_valid || s1_adv);
  assign s1_data    = s1_fwd ? fwd_data : ram_rdata;
  assign s1_sum     = s1_data + s1_weight;
  assign item_write = s1_valid && s1_wr && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr     <= do_write;
      s1_rd     <= do_read;
      s1_addr   <= rd_addr;
      s1_weight <= w_cw;
      s1_total  <= sequences_added_next;
      s1_status <= res_status;
      // same entry written back in this cycle: take the new word
      s1_fwd    <= s1_valid && s1_wr && (s1_addr == rd_addr);
      fwd_data  <= s1_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      sweep_addr <= '0;
    end else if (clearing) begin
      if (sweep_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        sweep_addr <= sweep_addr + AW'(1);
      end
    end else if (accept && func_t'(in_ch.func) == FUNC_CLEAR) begin
      clearing   <= 1'b1;
      sweep_addr <= '0;
    end
  end

  assign ram_we    = clearing || item_write;
  assign ram_waddr = clearing ? sweep_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : s1_sum;

  sccp_ram #(
    .WIDTH(CW),
    .DEPTH(DEPTH)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_ch.count_value     <= s1_rd ? OUT_W'(s1_data) : '0;
      out_ch.sequences_total <= OUT_W'(s1_total);
      out_ch.status          <= s1_status;
    end
  end

  assign out_ch.valid   = out_valid;
  assign mon.clearing   = clearing;
  assign mon.item_write = item_write;

endmodule

// ----- rtl/core/site_character_count_profile.sv -----
// top level of the site character count profile (position frequency matrix)
// depends on sccp_pkg, sccp_if, sccp_cfg, sccp_engine and assert_macros.svh
//
//   channel   dir  handshake       beat contents
//   in_ch     in   valid/ready     func, site_char, weight, last, query site/index
//   out_ch    out  valid/ready     count_value, sequences_total, status
//   apb       in   psel/penable    register write or read, pready always high
//
// one beat is accepted per cycle unless clearing or stalled; its result passes the read stage
// (count ram read at the accepting edge), then output register, so adds to one entry run back to back
// reset and every clear beat start a clearing pass over all MAX_SITES * ALPHABET_MAX entries
// of the count ram (32768 by default), ready low meanwhile
// a stalled result holds in the output register while one more beat is taken
`include "assert_macros.svh"

module site_character_count_profile #(
  parameter int MAX_SITES    = sccp_pkg::DEF_MAX_SITES,
  parameter int ALPHABET_MAX = sccp_pkg::DEF_ALPHABET_MAX,
  parameter int COUNT_BITS   = sccp_pkg::DEF_COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sccp_pkg::APB_AW-1:0] paddr,
  input  logic [sccp_pkg::APB_DW-1:0] pwdata,
  output logic [sccp_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  sccp_in_if.sink                     in_ch,
  sccp_out_if.source                  out_ch
);
  import sccp_pkg::*;

  sccp_cfg_t cfg;
  sccp_mon_t mon;

  sccp_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  sccp_engine #(
    .MAX_SITES   (MAX_SITES),
    .ALPHABET_MAX(ALPHABET_MAX),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .mon   (mon)
  );

  `SCCP_ASSERT_IMPL(a_sweep_excl, clk, rst, mon.clearing, !mon.item_write, "count write during clear")
  `SCCP_ASSERT_NEXT(a_clear_start, clk, rst, in_ch.valid && in_ch.ready && in_ch.func == FUNC_CLEAR, mon.clearing, "clear beat did not start clearing")
  `SCCP_ASSERT_IMPL(a_clear_block, clk, rst, mon.clearing, !in_ch.ready, "input taken while clearing")
  `SCCP_ASSERT_IMPL(a_invalid_zero, clk, rst, out_ch.valid && out_ch.status == ST_INVALID, out_ch.count_value == '0, "invalid query with nonzero count")

endmodule

// ----- dv/site_character_count_profile_tb.sv -----
// self-checking testbench for site_character_count_profile: directed beats, then random phases
// every result beat is checked against a built-in count-matrix predictor
// depends on sccp_pkg, sccp_in_if/sccp_out_if and the rtl top
module site_character_count_profile_tb;
  import sccp_pkg::*;

  localparam int SITES_MAX       = DEF_MAX_SITES;
  localparam int ALPHA_MAX       = DEF_ALPHABET_MAX;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int LIMIT_CYCLES    = 2_500_000;

  typedef struct {
    func_t     op;
    bit [7:0]  ch;
    bit [31:0] wt;
    bit        last;
    bit [11:0] qsite;
    bit [2:0]  qidx;
  } prof_item_t;

  typedef struct {
    bit [31:0] count;
    bit [31:0] total;
    status_t   st;
  } prof_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;

  sccp_in_if  in_ch();
  sccp_out_if out_ch();

  site_character_count_profile DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  bit [31:0]   pfm_counts [SITES_MAX*ALPHA_MAX];
  bit [31:0]   seq_total;
  int unsigned seq_pos;
  bit          seq_rej, len_err;
  bit [63:0]   cfg_chars;
  int unsigned cfg_size;
  int unsigned cfg_sites = SITES_MAX;

  prof_item_t   pending_items[$];
  prof_result_t due_results[$];
  prof_item_t   on_bus;
  int items_issued, items_taken, mismatches, clears_left = 4;
  int send_idle_pct, rcv_idle_pct;
  bit hold_armed, hold_done;
  int hold_left;

  function automatic bit [7:0] fold_case(input bit [7:0] c);
    return (c inside {[8'h61:8'h7a]}) ? {c[7:6], 1'b0, c[4:0]} : c;
  endfunction

  function automatic int unsigned alpha_index(input bit [7:0] c);
    int unsigned na;
    na = (cfg_size > ALPHA_MAX) ? ALPHA_MAX : cfg_size;
    for (int unsigned k = 0; k < na; k++)
      if (fold_case(cfg_chars[8*k +: 8]) == fold_case(c)) return k;
    return na;
  endfunction

  function automatic void wipe_profile();
    foreach (pfm_counts[i]) pfm_counts[i] = '0;
    seq_total = '0;
    seq_pos = 0;
    seq_rej = 1'b0;
    len_err = 1'b0;
  endfunction

  function automatic void profile_predict(input prof_item_t it);
    prof_result_t r;
    int unsigned len, na, idx;
    r.count = '0;
    r.st = ST_OK;
    len = (cfg_sites > SITES_MAX) ? SITES_MAX : cfg_sites;
    na = (cfg_size > ALPHA_MAX) ? ALPHA_MAX : cfg_size;
    case (it.op)
      FUNC_ADD: begin
        if (seq_pos == 0) begin
          seq_rej = (seq_total >= (32'hFFFF_FFFF - it.wt));
          len_err = 1'b0;
        end
        if (!seq_rej) begin
          if (seq_pos < len) begin
            idx = alpha_index(it.ch);
            if (idx < na) pfm_counts[seq_pos*ALPHA_MAX + idx] += it.wt;
          end else begin
            len_err = 1'b1;
          end
        end
        if (seq_pos < 8191) seq_pos++;
        if (it.last && !seq_rej) begin
          if (seq_pos != len) len_err = 1'b1;
          seq_total += it.wt;
        end
        r.st = seq_rej ? ST_REJECTED : (len_err ? ST_LENGTH : ST_OK);
        if (it.last) begin
          seq_pos = 0;
          seq_rej = 1'b0;
          len_err = 1'b0;
        end
      end
      FUNC_READ_CHAR, FUNC_READ_INDEX: begin
        idx = (it.op == FUNC_READ_CHAR) ? alpha_index(it.ch) : it.qidx;
        if (it.qsite < len && idx < na) r.count = pfm_counts[it.qsite*ALPHA_MAX + idx];
        else r.st = ST_INVALID;
      end
      default: wipe_profile();
    endcase
    r.total = seq_total;
    due_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        profile_predict(on_bus);
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.func             <= on_bus.op;
          in_ch.site_char        <= on_bus.ch;
          in_ch.weight           <= on_bus.wt;
          in_ch.last_of_sequence <= on_bus.last;
          in_ch.query_site       <= on_bus.qsite;
          in_ch.query_char_index <= on_bus.qidx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with a single long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    prof_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("beat with none due", out_ch.count_value, '0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.count_value !== want.count)
          report_mismatch("count_value", out_ch.count_value, want.count);
        if (out_ch.sequences_total !== want.total)
          report_mismatch("sequences_total", out_ch.sequences_total, want.total);
        if (out_ch.status !== want.st)
          report_mismatch("status", 32'(out_ch.status), 32'(want.st));
      end
    end
  end

  task automatic apb_write(input logic [1:0] regi, input logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regi, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_profile(input bit [63:0] chars, input int unsigned size,
                             input int unsigned sites);
    apb_write(REG_ALPHABET_CHARS, chars);
    apb_write(REG_ALPHABET_SIZE, 64'(size));
    apb_write(REG_SITE_COUNT, 64'(sites));
    cfg_chars = chars;
    cfg_size  = size & 4'hF;
    cfg_sites = sites & 13'h1FFF;
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct <= snd;
    rcv_idle_pct  <= rcv;
  endtask

  task automatic wait_idle();
    while (items_taken != items_issued) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_item(input func_t op, input bit [7:0] ch, input bit [31:0] wt,
                           input bit last, input bit [11:0] qsite, input bit [2:0] qidx);
    prof_item_t it;
    it.op = op;
    it.ch = ch;
    it.wt = wt;
    it.last = last;
    it.qsite = qsite;
    it.qidx = qidx;
    pending_items.push_back(it);
    items_issued++;
  endtask

  function automatic bit [7:0] pick_char();
    bit [7:0] c;
    if ($urandom_range(3) == 0) return 8'($urandom);
    c = cfg_chars[8*$urandom_range(0, 7) +: 8];
    if (c[6] && $urandom_range(1)) c[5] = ~c[5];
    return c;
  endfunction

  function automatic bit [31:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 2) return '1;
    if (r < 4) return $urandom;
    if (r < 10) return '0;
    if (r < 55) return 32'd1;
    return $urandom_range(2, 5000);
  endfunction

  function automatic bit [63:0] random_alphabet();
    bit [63:0] a;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(9))
        0: a[8*k +: 8] = 8'($urandom);
        1, 2: a[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 25));
        default: a[8*k +: 8] = 8'h41 + 8'($urandom_range(0, 25));
      endcase
    end
    return a;
  endfunction

  task automatic push_sequence(input int unsigned n, input bit [31:0] wt);
    for (int unsigned i = 0; i < n; i++)
      push_item(FUNC_ADD, pick_char(), wt, i == n - 1, $urandom_range(0, 4095),
                $urandom_range(0, 7));
  endtask

  task automatic fill_phase(input int n);
    int start, r;
    int unsigned len;
    start = items_issued;
    while (items_issued - start < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        push_sequence((cfg_sites <= 16) ? cfg_sites : $urandom_range(1, 12), pick_weight());
      end else if (r < 77) begin
        // short or surplus sequence
        if (cfg_sites > 16) len = $urandom_range(1, 12);
        else if (cfg_sites < 2 || $urandom_range(1)) len = cfg_sites + $urandom_range(1, 3);
        else len = $urandom_range(1, cfg_sites - 1);
        push_sequence(len, pick_weight());
      end else if (r < 93) begin
        push_item(func_t'($urandom_range(1, 2)), pick_char(), $urandom, $urandom_range(1),
                  ($urandom_range(9) < 7) ? $urandom_range(0, cfg_sites - 1)
                                          : $urandom_range(0, 4095),
                  $urandom_range(0, 7));
      end else if (r < 99) begin
        push_item(func_t'($urandom_range(0, 2)), 8'($urandom), $urandom, $urandom_range(1),
                  $urandom_range(0, 4095), $urandom_range(0, 7));
      end else if (clears_left > 0) begin
        clears_left--;
        push_item(FUNC_CLEAR, 8'($urandom), $urandom, $urandom_range(1),
                  $urandom_range(0, 4095), $urandom_range(0, 7));
      end
    end
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ADD;
    in_ch.site_char = '0;
    in_ch.weight = '0;
    in_ch.last_of_sequence = 1'b0;
    in_ch.query_site = '0;
    in_ch.query_char_index = '0;
    out_ch.ready = 1'b0;
    wipe_profile();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // alphabet A C G T N a c g: lower-case copies duplicate earlier entries
    set_profile(64'h6763614E54474341, ALPHA_MAX, 3);
    set_idling(22, 57);
    push_item(FUNC_ADD, "A", 32'd1, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "c", 32'd1, 1'b0, 12'hFFF, 3'd7);
    push_item(FUNC_ADD, "G", 32'd1, 1'b1, 12'd0, 3'd0);
    // all-ones weight overflows
    push_item(FUNC_ADD, "x", 32'hFFFF_FFFF, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "T", 32'hFFFF_FFFF, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "n", 32'hFFFF_FFFF, 1'b1, 12'd0, 3'd0);
    // just fits, total lands one below the top
    push_item(FUNC_ADD, "a", 32'hFFFF_FFFD, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "T", 32'hFFFF_FFFD, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "g", 32'hFFFF_FFFD, 1'b1, 12'd0, 3'd0);
    push_item(FUNC_ADD, "N", 32'd1, 1'b1, 12'd0, 3'd0);
    push_item(FUNC_CLEAR, 8'hFF, 32'd0, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "A", 32'd7, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "C", 32'd7, 1'b1, 12'd0, 3'd0);
    push_item(FUNC_ADD, "G", 32'd3, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "T", 32'd3, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "A", 32'd3, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "C", 32'd3, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_ADD, "N", 32'd3, 1'b1, 12'd0, 3'd0);
    push_item(FUNC_READ_CHAR, "a", 32'd0, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_READ_CHAR, "z", 32'd0, 1'b0, 12'd1, 3'd0);
    push_item(FUNC_READ_INDEX, 8'h00, 32'd0, 1'b0, 12'd2, 3'd7);
    push_item(FUNC_READ_INDEX, 8'h00, 32'd0, 1'b0, 12'd3, 3'd2);
    push_item(FUNC_READ_INDEX, 8'h00, 32'd0, 1'b0, 12'hFFF, 3'd0);
    push_item(FUNC_ADD, "T", 32'd5, 1'b0, 12'd0, 3'd0);
    push_item(FUNC_CLEAR, 8'h00, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 3'd7);
    push_item(FUNC_READ_INDEX, 8'h00, 32'd0, 1'b0, 12'd1, 3'd1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_profile(random_alphabet(), ALPHA_MAX, 1);
        1: set_profile(random_alphabet(), $urandom_range(1, 7), $urandom_range(2, 6));
        2: set_profile(random_alphabet(), 4, SITES_MAX);
        3: set_profile(random_alphabet(), 0, 5);
        4: set_profile(random_alphabet(), $urandom_range(0, 8), $urandom_range(1, 8));
        default: set_profile({$urandom, $urandom}, ALPHA_MAX, $urandom_range(2, 8));
      endcase
      if (ph < 2) set_idling(22, 57);
      else if (ph < 4) set_idling(57, 22);
      else set_idling(0, 0);
      fill_phase(155);
      if (ph == 0) hold_armed <= 1'b1;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sccp_pkg.sv
rtl/core/sccp_if.sv
rtl/core/sccp_ram.sv
rtl/core/sccp_cfg.sv
rtl/core/sccp_engine.sv
rtl/core/site_character_count_profile.sv
dv/site_character_count_profile_tb.sv
